// File: rtl/core/i2c_eeprom_transfer_sequencer_assert.svh
// assertion macros for the i2c eeprom transfer sequencer
// expects clk and rst_n in the scope of each use
`ifndef I2C_EEPROM_TRANSFER_SEQUENCER_ASSERT_SVH
`define I2C_EEPROM_TRANSFER_SEQUENCER_ASSERT_SVH

// same-cycle implication
`define EETS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define EETS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/eets_pkg.sv
// types, codes and helpers shared by the i2c eeprom transfer sequencer
// no dependencies
package eets_pkg;

    localparam int unsigned CFG_DATA_W = 17;

    typedef enum logic [1:0] {
        REG_CHIP_ADDR   = 2'd0,
        REG_PAGE_LOG2   = 2'd1,
        REG_MAX_READ    = 2'd2,
        REG_SINGLE_ADDR = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ACT_START  = 2'd0,
        ACT_BUSERR = 2'd1,
        ACT_MASTER = 2'd2,
        ACT_SLAVE  = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        CMD_NONE     = 3'd0,
        CMD_DATA     = 3'd1,
        CMD_ADDR     = 3'd2,
        CMD_STOP     = 3'd3,
        CMD_ACK_READ = 3'd4,
        CMD_CLEAR    = 3'd5
    } cmd_t;

    typedef enum logic [2:0] {
        PH_HALTED   = 3'd0,
        PH_START    = 3'd1,
        PH_ADDR_HB  = 3'd2,
        PH_ADDR_LB  = 3'd3,
        PH_WRITE    = 3'd4,
        PH_READ     = 3'd5,
        PH_ERR_XFER = 3'd6,
        PH_ERR_CMP  = 3'd7
    } phase_t;

    typedef enum logic [1:0] {
        ST_BUSY    = 2'd0,
        ST_DONE    = 2'd1,
        ST_XFER    = 2'd2,
        ST_COMPARE = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0]  chip_write_address;
        logic [3:0]  page_size_log2;
        logic [16:0] max_read_bytes;
        logic        single_byte_addressing;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  action;
        logic        direction;
        logic        compare_mode;
        logic [15:0] mem_address;
        logic        arb_lost;
        logic        rx_nack;
        logic [7:0]  rx_byte;
        logic [7:0]  buffer_byte;
        logic        buffer_has_byte;
    } item_t;

    typedef struct packed {
        phase_t      phase;
        logic        is_read;
        logic        is_compare;
        logic [8:0]  page_bytes_left;
        logic [16:0] bytes_stored;
    } seq_state_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [7:0]  value;
        logic        send_nack;
        logic        take;
        logic        store;
        status_t     status;
    } result_t;

    function automatic status_t status_of(input phase_t ph);
        status_t st;
        unique case (ph)
            PH_HALTED:   st = ST_DONE;
            PH_ERR_XFER: st = ST_XFER;
            PH_ERR_CMP:  st = ST_COMPARE;
            default:     st = ST_BUSY;
        endcase
        return st;
    endfunction

endpackage

// File: rtl/core/i2c_eeprom_transfer_sequencer.sv
// top level of the i2c eeprom transfer sequencer: config, state and result registers
// depends on eets_pkg, eets_in_stage, eets_step and the assertion macro header
//
// One bus event item is taken per clock while in_ready is high. An accepted item goes to
// the input register; the sequencer state and the result register are then updated from
// it together once the result register is empty or out_ready is high. The combinational
// state update in eets_step sets that rate; while a result waits for out_ready the input
// register holds one more item and then in_ready drops. Configuration takes effect on the
// next item; the user must write it only while idle, which the block itself does not enforce.
module i2c_eeprom_transfer_sequencer #(
    parameter int unsigned ADDR_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [eets_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic        direction,
    input  logic        compare_mode,
    input  logic [15:0] mem_address,
    input  logic        arb_lost,
    input  logic        rx_nack,
    input  logic [7:0]  rx_byte,
    input  logic [7:0]  buffer_byte,
    input  logic        buffer_has_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  bus_command,
    output logic [7:0]  bus_value,
    output logic        send_nack,
    output logic        take_buffer_byte,
    output logic        store_byte,
    output logic [1:0]  transfer_status
);
    import eets_pkg::*;

    cfg_t                 cfg_reg;
    seq_state_t           state_reg;
    seq_state_t           state_next;
    logic [ADDR_BITS-1:0] addr_reg;
    logic [ADDR_BITS-1:0] addr_next;
    result_t              result_reg;
    result_t              result_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    item_t                item_in;
    item_t                stage_item;
    logic                 stage_valid;
    logic                 advance;

    assign item_in.action          = action;
    assign item_in.direction       = direction;
    assign item_in.compare_mode    = compare_mode;
    assign item_in.mem_address     = mem_address;
    assign item_in.arb_lost        = arb_lost;
    assign item_in.rx_nack         = rx_nack;
    assign item_in.rx_byte         = rx_byte;
    assign item_in.buffer_byte     = buffer_byte;
    assign item_in.buffer_has_byte = buffer_has_byte;

    assign advance = stage_valid && (!out_valid_reg || out_ready);

    eets_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .item_in     (item_in),
        .advance     (advance),
        .stage_valid (stage_valid),
        .stage_item  (stage_item)
    );

    eets_step #(
        .ADDR_BITS (ADDR_BITS)
    ) u_step (
        .cfg        (cfg_reg),
        .item       (stage_item),
        .state      (state_reg),
        .cur_addr   (addr_reg),
        .state_next (state_next),
        .addr_next  (addr_next),
        .result     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.chip_write_address     <= 8'd160;
            cfg_reg.page_size_log2         <= 4'd6;
            cfg_reg.max_read_bytes         <= 17'h10000;
            cfg_reg.single_byte_addressing <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_CHIP_ADDR:   cfg_reg.chip_write_address     <= cfg_data[7:0];
                REG_PAGE_LOG2:   cfg_reg.page_size_log2         <= cfg_data[3:0];
                REG_MAX_READ:    cfg_reg.max_read_bytes         <= cfg_data;
                REG_SINGLE_ADDR: cfg_reg.single_byte_addressing <= cfg_data[0];
            endcase
        end
    end

    always_comb
    begin
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase           <= PH_HALTED;
            state_reg.is_read         <= 1'b0;
            state_reg.is_compare      <= 1'b0;
            state_reg.page_bytes_left <= 9'd0;
            state_reg.bytes_stored    <= 17'd0;
            addr_reg                  <= '0;
            out_valid_reg             <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
                addr_reg  <= addr_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign bus_command      = result_reg.cmd;
    assign bus_value        = result_reg.value;
    assign send_nack        = result_reg.send_nack;
    assign take_buffer_byte = result_reg.take;
    assign store_byte       = result_reg.store;
    assign transfer_status  = result_reg.status;

`include "i2c_eeprom_transfer_sequencer_assert.svh"

    `EETS_ASSERT_IMP(a_store_acks, out_valid_reg && result_reg.store,
        result_reg.cmd == CMD_ACK_READ, "stored byte without ack and read next")
    `EETS_ASSERT_IMP(a_nack_stops, out_valid_reg && result_reg.send_nack,
        result_reg.cmd == CMD_STOP, "nack without stop")
    `EETS_ASSERT_NXT(a_advance_fills, advance, out_valid_reg, "processed item lost its result")
    `EETS_ASSERT_IMP(a_write_phase, state_reg.phase == PH_WRITE, !state_reg.is_read,
        "write phase during a read transfer")

endmodule

// File: rtl/core/eets_in_stage.sv
// input register of the sequencer: holds one accepted item
// depends on eets_pkg
module eets_in_stage
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  eets_pkg::item_t item_in,
    input  logic          advance,
    output logic          stage_valid,
    output eets_pkg::item_t stage_item
);
    import eets_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign in_ready    = !valid_reg || advance;
    assign stage_valid = valid_reg;
    assign stage_item  = item_reg;

    always_comb
    begin
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_in;
        end
    end

endmodule

// File: rtl/core/eets_step.sv
// next-state and result logic for one item of the sequencer
// depends on eets_pkg
module eets_step #(
    parameter int unsigned ADDR_BITS = 16
)
(
    input  eets_pkg::cfg_t       cfg,
    input  eets_pkg::item_t      item,
    input  eets_pkg::seq_state_t state,
    input  logic [ADDR_BITS-1:0] cur_addr,
    output eets_pkg::seq_state_t state_next,
    output logic [ADDR_BITS-1:0] addr_next,
    output eets_pkg::result_t    result
);
    import eets_pkg::*;

    logic [3:0]  lg;
    logic [8:0]  psize;
    logic [15:0] cur16;
    logic [15:0] new16;
    logic [15:0] shifted;
    logic [8:0]  offset;
    logic        ok;
    phase_t      ph_next;

    assign lg      = (cfg.page_size_log2 > 4'd8) ? 4'd8 : cfg.page_size_log2;
    assign psize   = 9'd1 << lg;
    assign cur16   = 16'(cur_addr);
    assign new16   = 16'(item.mem_address[ADDR_BITS-1:0]);
    assign shifted = cur16 >> lg;
    assign offset  = {1'b0, new16[7:0]} & (psize - 9'd1);

    always_comb
    begin
        state_next       = state;
        addr_next        = cur_addr;
        ph_next          = state.phase;
        result.cmd       = CMD_NONE;
        result.value     = 8'd0;
        result.send_nack = 1'b0;
        result.take      = 1'b0;
        result.store     = 1'b0;
        ok               = 1'b0;
        unique case (action_t'(item.action))
            ACT_START:
            begin
                state_next.is_read         = item.direction;
                state_next.is_compare      = item.direction & item.compare_mode;
                addr_next                  = item.mem_address[ADDR_BITS-1:0];
                state_next.page_bytes_left = psize - offset;
                state_next.bytes_stored    = 17'd0;
                ph_next                    = PH_START;
                result.cmd                 = CMD_ADDR;
                result.value               = cfg.chip_write_address;
            end
            ACT_BUSERR:
            begin
                ph_next    = PH_ERR_XFER;
                result.cmd = CMD_CLEAR;
            end
            ACT_MASTER:
            begin
                if (item.arb_lost || item.rx_nack)
                begin
                    ph_next    = PH_ERR_XFER;
                    result.cmd = CMD_STOP;
                end
                else if (state.phase == PH_START)
                begin
                    result.cmd = CMD_DATA;
                    if (cfg.single_byte_addressing)
                    begin
                        ph_next      = PH_ADDR_LB;
                        result.value = shifted[7:0];
                    end
                    else
                    begin
                        ph_next      = PH_ADDR_HB;
                        result.value = cur16[15:8];
                    end
                end
                else if (state.phase == PH_ADDR_HB)
                begin
                    ph_next      = PH_ADDR_LB;
                    result.cmd   = CMD_DATA;
                    result.value = cur16[7:0];
                end
                else if (state.phase == PH_ADDR_LB)
                begin
                    if (state.is_read)
                    begin
                        ph_next      = PH_READ;
                        result.cmd   = CMD_ADDR;
                        result.value = cfg.chip_write_address + 8'd1;
                    end
                    else
                    begin
                        ph_next = PH_WRITE;
                    end
                end
                else if (state.phase == PH_WRITE)
                begin
                    if (state.page_bytes_left == 9'd0 || !item.buffer_has_byte)
                    begin
                        ph_next    = PH_HALTED;
                        result.cmd = CMD_STOP;
                    end
                    else
                    begin
                        result.cmd                 = CMD_DATA;
                        result.value               = item.buffer_byte;
                        result.take                = 1'b1;
                        state_next.page_bytes_left = state.page_bytes_left - 9'd1;
                    end
                end
                else
                begin
                    result.cmd = CMD_CLEAR;
                end
            end
            ACT_SLAVE:
            begin
                if (item.rx_nack)
                begin
                    ph_next    = PH_HALTED;
                    result.cmd = CMD_STOP;
                end
                else
                begin
                    if (state.is_compare)
                    begin
                        if (item.buffer_has_byte)
                        begin
                            result.take = 1'b1;
                            ok          = (item.buffer_byte == item.rx_byte);
                            if (!ok)
                            begin
                                ph_next = PH_ERR_CMP;
                            end
                        end
                    end
                    else if (state.bytes_stored < cfg.max_read_bytes)
                    begin
                        ok                      = 1'b1;
                        result.store            = 1'b1;
                        state_next.bytes_stored = state.bytes_stored + 17'd1;
                    end
                    if (ok)
                    begin
                        result.cmd = CMD_ACK_READ;
                    end
                    else
                    begin
                        if (ph_next != PH_ERR_CMP)
                        begin
                            ph_next = PH_HALTED;
                        end
                        result.send_nack = 1'b1;
                        result.cmd       = CMD_STOP;
                    end
                end
            end
        endcase
        state_next.phase = ph_next;
        result.status    = status_of(ph_next);
    end

endmodule

// File: tb/tb_i2c_eeprom_transfer_sequencer.sv
// testbench for the i2c eeprom transfer sequencer: directed and random bus event items,
// checked against an in-bench model of the transfer state machine
// depends on eets_pkg and the i2c_eeprom_transfer_sequencer rtl
module tb_i2c_eeprom_transfer_sequencer;
    import eets_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 1000;
    localparam int unsigned IDLE_LIMIT = 4000;
    localparam int unsigned HOLD_CYCLES = 300;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    cfg_reg_t cfg_index = REG_CHIP_ADDR;
    logic [16:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    item_t ev_bus = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [2:0] bus_command;
    logic [7:0] bus_value;
    logic send_nack;
    logic take_buffer_byte;
    logic store_byte;
    logic [1:0] transfer_status;

    // register shadow, reset values
    logic [7:0] cfg_chip = 8'd160;
    logic [3:0] cfg_page_log2 = 4'd6;
    logic [16:0] cfg_max_read = 17'd65536;
    logic cfg_single = 1'b0;

    // transfer state as the block should hold it
    phase_t seq_phase = PH_HALTED;
    logic seq_read = 1'b0;
    logic seq_compare = 1'b0;
    logic [15:0] seq_addr = '0;
    logic [8:0] seq_page_left = '0;
    logic [16:0] seq_stored = '0;

    result_t pending_bus_ops[$];
    int unsigned sent_items = 0;
    int unsigned mismatches = 0;
    int unsigned idle_cycles = 0;
    int unsigned hold_request = 0;
    bit send_gaps = 1'b1;
    bit recv_stalls = 1'b1;

    always #5 clk = ~clk;

    i2c_eeprom_transfer_sequencer uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .action(ev_bus.action),
        .direction(ev_bus.direction),
        .compare_mode(ev_bus.compare_mode),
        .mem_address(ev_bus.mem_address),
        .arb_lost(ev_bus.arb_lost),
        .rx_nack(ev_bus.rx_nack),
        .rx_byte(ev_bus.rx_byte),
        .buffer_byte(ev_bus.buffer_byte),
        .buffer_has_byte(ev_bus.buffer_has_byte),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .bus_command(bus_command),
        .bus_value(bus_value),
        .send_nack(send_nack),
        .take_buffer_byte(take_buffer_byte),
        .store_byte(store_byte),
        .transfer_status(transfer_status)
    );

    function automatic result_t predict_bus_op(input item_t ev);
        result_t r;
        int unsigned lg;
        int unsigned psize;
        logic ok;
        r = '0;
        r.cmd = CMD_NONE;
        ok = 1'b0;
        lg = (cfg_page_log2 > 4'd8) ? 8 : cfg_page_log2;
        psize = 1 << lg;
        case (ev.action)
            ACT_START:
            begin
                seq_read = ev.direction;
                seq_compare = ev.direction & ev.compare_mode;
                seq_addr = ev.mem_address;
                seq_page_left = 9'(psize - (seq_addr & (psize - 1)));
                seq_stored = '0;
                seq_phase = PH_START;
                r.cmd = CMD_ADDR;
                r.value = cfg_chip;
            end
            ACT_BUSERR:
            begin
                seq_phase = PH_ERR_XFER;
                r.cmd = CMD_CLEAR;
            end
            ACT_MASTER:
            begin
                if (ev.arb_lost || ev.rx_nack)
                begin
                    seq_phase = PH_ERR_XFER;
                    r.cmd = CMD_STOP;
                end
                else
                begin
                    case (seq_phase)
                        PH_START:
                        begin
                            r.cmd = CMD_DATA;
                            if (cfg_single)
                            begin
                                seq_phase = PH_ADDR_LB;
                                r.value = 8'(seq_addr >> lg);
                            end
                            else
                            begin
                                seq_phase = PH_ADDR_HB;
                                r.value = seq_addr[15:8];
                            end
                        end
                        PH_ADDR_HB:
                        begin
                            seq_phase = PH_ADDR_LB;
                            r.cmd = CMD_DATA;
                            r.value = seq_addr[7:0];
                        end
                        PH_ADDR_LB:
                        begin
                            if (seq_read)
                            begin
                                seq_phase = PH_READ;
                                r.cmd = CMD_ADDR;
                                r.value = cfg_chip + 8'd1;
                            end
                            else
                                seq_phase = PH_WRITE;
                        end
                        PH_WRITE:
                        begin
                            if (seq_page_left == 0 || !ev.buffer_has_byte)
                            begin
                                seq_phase = PH_HALTED;
                                r.cmd = CMD_STOP;
                            end
                            else
                            begin
                                r.cmd = CMD_DATA;
                                r.value = ev.buffer_byte;
                                r.take = 1'b1;
                                seq_page_left = seq_page_left - 9'd1;
                            end
                        end
                        default:
                            r.cmd = CMD_CLEAR;
                    endcase
                end
            end
            default:
            begin
                if (ev.rx_nack)
                begin
                    seq_phase = PH_HALTED;
                    r.cmd = CMD_STOP;
                end
                else
                begin
                    if (seq_compare)
                    begin
                        if (ev.buffer_has_byte)
                        begin
                            r.take = 1'b1;
                            ok = (ev.buffer_byte == ev.rx_byte);
                            if (!ok)
                                seq_phase = PH_ERR_CMP;
                        end
                    end
                    else if (seq_stored < cfg_max_read)
                    begin
                        ok = 1'b1;
                        r.store = 1'b1;
                        seq_stored = seq_stored + 17'd1;
                    end
                    if (ok)
                        r.cmd = CMD_ACK_READ;
                    else
                    begin
                        if (seq_phase != PH_ERR_CMP)
                            seq_phase = PH_HALTED;
                        r.send_nack = 1'b1;
                        r.cmd = CMD_STOP;
                    end
                end
            end
        endcase
        r.status = (seq_phase == PH_HALTED) ? ST_DONE :
                   (seq_phase == PH_ERR_XFER) ? ST_XFER :
                   (seq_phase == PH_ERR_CMP) ? ST_COMPARE : ST_BUSY;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [16:0] got,
                                   input logic [16:0] want);
        $display("%0t mismatch on %s: got %h want %h", $time, what, got, want);
        mismatches++;
    endtask

    function automatic int unsigned pick_pause(input bit enabled);
        int unsigned r;
        if (!enabled)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // result sink with random stalls and the occasional long hold-off
    initial
    begin : result_sink
        int unsigned n;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_request != 0)
            begin
                n = hold_request;
                hold_request = 0;
                out_ready <= 1'b0;
                repeat (n) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
            begin
                n = pick_pause(recv_stalls);
                if (n != 0)
                begin
                    out_ready <= 1'b0;
                    repeat (n) @(posedge clk);
                end
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_bus_ops.size() == 0)
                report_mismatch("unexpected item", 17'(bus_command), '0);
            else
            begin
                want = pending_bus_ops.pop_front();
                if (bus_command !== want.cmd)
                    report_mismatch("bus_command", 17'(bus_command), 17'(want.cmd));
                if (bus_value !== want.value)
                    report_mismatch("bus_value", 17'(bus_value), 17'(want.value));
                if (send_nack !== want.send_nack)
                    report_mismatch("send_nack", 17'(send_nack), 17'(want.send_nack));
                if (take_buffer_byte !== want.take)
                    report_mismatch("take_buffer_byte", 17'(take_buffer_byte),
                                    17'(want.take));
                if (store_byte !== want.store)
                    report_mismatch("store_byte", 17'(store_byte), 17'(want.store));
                if (transfer_status !== want.status)
                    report_mismatch("transfer_status", 17'(transfer_status),
                                    17'(want.status));
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb_i2c_eeprom_transfer_sequencer: errors");
            $finish;
        end
    end

    task automatic send_event(input item_t ev);
        int unsigned gap;
        gap = pick_pause(send_gaps);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        ev_bus <= ev;
        do
            @(posedge clk);
        while (!in_ready);
        pending_bus_ops.push_back(predict_bus_op(ev));
        sent_items++;
    endtask

    // sender goes quiet until every result is back
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_bus_ops.size() != 0);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [16:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_CHIP_ADDR: cfg_chip = val[7:0];
            REG_PAGE_LOG2: cfg_page_log2 = val[3:0];
            REG_MAX_READ: cfg_max_read = val;
            default: cfg_single = val[0];
        endcase
    endtask

    task automatic configure(input logic [7:0] chip, input logic [3:0] page_log2,
                             input logic [16:0] max_read, input logic single);
        drain_results();
        write_reg(REG_CHIP_ADDR, 17'(chip));
        write_reg(REG_PAGE_LOG2, 17'(page_log2));
        write_reg(REG_MAX_READ, max_read);
        write_reg(REG_SINGLE_ADDR, 17'(single));
    endtask

    function automatic item_t plain_event(input action_t act);
        item_t ev;
        ev = '0;
        ev.action = act;
        return ev;
    endfunction

    function automatic item_t random_event();
        item_t ev;
        ev.action = 2'($urandom_range(0, 3));
        ev.direction = 1'($urandom);
        ev.compare_mode = 1'($urandom);
        ev.mem_address = 16'($urandom);
        ev.arb_lost = 1'($urandom);
        ev.rx_nack = 1'($urandom);
        ev.rx_byte = 8'($urandom);
        ev.buffer_byte = 8'($urandom);
        ev.buffer_has_byte = 1'($urandom);
        return ev;
    endfunction

    function automatic item_t master_event(input bit data_byte);
        item_t ev;
        int unsigned r;
        ev = random_event();
        ev.action = ACT_MASTER;
        r = $urandom_range(0, 59);
        ev.arb_lost = (r == 0);
        ev.rx_nack = (r == 1);
        if (data_byte)
            ev.buffer_has_byte = ($urandom_range(0, 11) != 0);
        return ev;
    endfunction

    function automatic item_t slave_event();
        item_t ev;
        ev = random_event();
        ev.action = ACT_SLAVE;
        ev.rx_nack = ($urandom_range(0, 39) == 0);
        if ($urandom_range(0, 9) != 0)
            ev.buffer_byte = ev.rx_byte;
        ev.buffer_has_byte = ($urandom_range(0, 14) != 0);
        return ev;
    endfunction

    // start, address bytes, then data bytes out or read bytes in
    task automatic run_transfer(input bit rd, input bit cmp, input int unsigned len);
        item_t ev;
        ev = random_event();
        ev.action = ACT_START;
        ev.direction = rd;
        ev.compare_mode = cmp;
        send_event(ev);
        repeat (cfg_single ? 2 : 3) send_event(master_event(1'b0));
        repeat (len) send_event(rd ? slave_event() : master_event(1'b1));
    endtask

    task automatic test_page_write();
        item_t ev;
        configure(8'd254, 4'd2, 17'd65536, 1'b0);
        ev = plain_event(ACT_START);
        ev.compare_mode = 1'b1;
        ev.mem_address = 16'hfffe;
        send_event(ev);
        repeat (3) send_event(plain_event(ACT_MASTER));
        ev = plain_event(ACT_MASTER);
        ev.buffer_has_byte = 1'b1;
        ev.buffer_byte = 8'hff;
        send_event(ev);
        ev.buffer_byte = 8'h00;
        send_event(ev);
        send_event(ev);
    endtask

    task automatic test_stored_read();
        item_t ev;
        configure(8'd0, 4'd15, 17'd1, 1'b1);
        ev = plain_event(ACT_START);
        ev.direction = 1'b1;
        ev.mem_address = 16'h1234;
        send_event(ev);
        repeat (2) send_event(plain_event(ACT_MASTER));
        ev = plain_event(ACT_SLAVE);
        ev.rx_byte = 8'hff;
        send_event(ev);
        ev.rx_byte = 8'h00;
        send_event(ev);
    endtask

    task automatic test_compare_read();
        item_t ev;
        ev = plain_event(ACT_START);
        ev.direction = 1'b1;
        ev.compare_mode = 1'b1;
        send_event(ev);
        repeat (2) send_event(plain_event(ACT_MASTER));
        ev = plain_event(ACT_SLAVE);
        ev.buffer_has_byte = 1'b1;
        ev.rx_byte = 8'ha5;
        ev.buffer_byte = 8'ha5;
        send_event(ev);
        ev.rx_byte = 8'h00;
        ev.buffer_byte = 8'hff;
        send_event(ev);
        send_event(plain_event(ACT_SLAVE));
    endtask

    task automatic test_bus_events();
        item_t ev;
        send_event(plain_event(ACT_BUSERR));
        send_event(plain_event(ACT_MASTER));
        ev = plain_event(ACT_SLAVE);
        ev.rx_nack = 1'b1;
        send_event(ev);
        send_event(plain_event(ACT_MASTER));
        ev = plain_event(ACT_START);
        ev.direction = 1'b1;
        send_event(ev);
        ev = plain_event(ACT_START);
        ev.mem_address = 16'h00ff;
        send_event(ev);
        ev = plain_event(ACT_MASTER);
        ev.arb_lost = 1'b1;
        send_event(ev);
        ev = plain_event(ACT_SLAVE);
        ev.rx_byte = 8'h5a;
        send_event(ev);
    endtask

    task automatic test_backpressure();
        drain_results();
        send_gaps = 1'b0;
        hold_request = HOLD_CYCLES;
        repeat (6) run_transfer(1'($urandom), 1'($urandom), $urandom_range(2, 6));
        drain_results();
        send_gaps = 1'b1;
    endtask

    task automatic test_random_traffic();
        int unsigned setup_no;
        int unsigned stop_at;
        int unsigned len;
        logic [16:0] max_read;
        setup_no = 0;
        stop_at = sent_items + RANDOM_ITEMS;
        while (sent_items < stop_at)
        begin
            if ($urandom_range(0, 3) == 0)
                max_read = 17'($urandom_range(1, 65536));
            else
                max_read = 17'($urandom_range(1, 8));
            case (setup_no)
                0: configure(8'd0, 4'd0, 17'd1, 1'b0);
                1: configure(8'd254, 4'd8, 17'd65536, 1'b1);
                2: configure(8'($urandom_range(0, 254)), 4'd15, max_read, 1'b0);
                default: configure(8'($urandom_range(0, 254)), 4'($urandom_range(0, 9)),
                                   max_read, 1'($urandom));
            endcase
            setup_no++;
            send_gaps = ($urandom_range(0, 3) != 0);
            recv_stalls = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(8, 20))
            begin
                if ($urandom_range(0, 9) == 0)
                    repeat ($urandom_range(1, 4)) send_event(random_event());
                else
                begin
                    if ($urandom_range(0, 99) < 85)
                        len = $urandom_range(0, 10);
                    else
                        len = $urandom_range(10, 80);
                    run_transfer(1'($urandom), 1'($urandom), len);
                end
            end
        end
        send_gaps = 1'b1;
        recv_stalls = 1'b1;
    endtask

    initial
    begin : test_sequence
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        test_page_write();
        test_stored_read();
        test_compare_read();
        test_bus_events();
        test_backpressure();
        test_random_traffic();
        drain_results();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && pending_bus_ops.size() == 0)
            $display("tb_i2c_eeprom_transfer_sequencer: clean");
        else
            $display("tb_i2c_eeprom_transfer_sequencer: errors");
        $finish;
    end

endmodule
